[design/jtl_pkg.sv]
// Shared types, codes and constants for the JSON token lexer.
// No dependencies; the other modules refer to this package by scoped names.
package jtl_pkg;

  localparam int unsigned POSITION_BITS_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH           = 4;

  // Token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COLON    = 4'd4,
    TK_COMMA    = 4'd5,
    TK_STRING   = 4'd6,
    TK_NUMBER   = 4'd7,
    TK_TRUE     = 4'd8,
    TK_FALSE    = 4'd9,
    TK_NULL     = 4'd10,
    TK_END      = 4'd11,
    TK_ERROR    = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_INT,
    M_FRAC,
    M_KW,
    M_HOLD
  } mode_t;

  // Keyword selector
  localparam logic [1:0] KW_SEL_TRUE  = 2'd0;
  localparam logic [1:0] KW_SEL_FALSE = 2'd1;
  localparam logic [1:0] KW_SEL_NULL  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LC_F     = 8'h66;
  localparam logic [7:0] CH_LC_N     = 8'h6E;
  localparam logic [7:0] CH_LC_T     = 8'h74;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  // Tokens caused by one byte: one, or two when two_tok is set
  typedef struct packed {
    logic   two_tok;
    token_t tok0;
    token_t tok1;
  } group_t;

  // Expected keyword character at a given progress
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_NUL;
    unique case (sel)
      KW_SEL_TRUE: begin
        case (idx)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = CH_NUL;
        endcase
      end
      KW_SEL_FALSE: begin
        case (idx)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = CH_NUL;
        endcase
      end
      KW_SEL_NULL: begin
        case (idx)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    logic [2:0] n;
    unique case (sel)
      KW_SEL_TRUE:  n = 3'd4;
      KW_SEL_FALSE: n = 3'd5;
      KW_SEL_NULL:  n = 3'd4;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

[design/jtl_byte_if.sv]
// Valid/ready channel carrying one document byte.
// No dependencies.
interface jtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

[design/jtl_token_if.sv]
// Valid/ready channel carrying one lexer token.
// No dependencies.
interface jtl_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] value_start;
  logic [15:0] value_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output value_start,
                  output value_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input value_start,
                  input value_length, input last_of_run, output ready);
endinterface

[design/jtl_front.sv]
// Front end: accepts bytes, runs the lexer state machine, emits token groups.
// Depends on jtl_pkg and jtl_byte_if.
module jtl_front #(
  parameter int unsigned POSITION_BITS = jtl_pkg::POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  jtl_byte_if.sink           in_ch,
  input  logic               q_full,
  output logic               push,
  output jtl_pkg::group_t    grp
);

  localparam int unsigned PB = POSITION_BITS;

  jtl_pkg::mode_t mode, mode_next;
  logic [2:0]     kw_prog, kw_prog_next;
  logic [1:0]     kw_sel, kw_sel_next;
  logic [PB-1:0]  pos, pos_next;
  logic [PB-1:0]  tok_begin, tok_begin_next;

  logic           accept;
  logic [7:0]     b;
  logic           is_digit;
  logic [PB-1:0]  here_plus1;
  logic [PB-1:0]  run_len;

  // outcome of lexing the byte from the idle mode
  logic           idle_emit;
  logic [3:0]     idle_kind;
  logic           idle_done;
  jtl_pkg::mode_t idle_mode;
  logic           idle_str;
  logic           idle_num;
  logic           idle_kw;
  logic [1:0]     idle_sel;

  logic           use_idle;
  logic           done;
  logic [1:0]     n_tok;
  jtl_pkg::token_t tok0, tok1;
  logic           kw_match;
  logic [2:0]     kw_prog_inc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;
  assign is_digit    = (b >= jtl_pkg::CH_ZERO) && (b <= jtl_pkg::CH_NINE);
  assign here_plus1  = pos + PB'(1);
  assign run_len     = pos - tok_begin;
  assign kw_prog_inc = kw_prog + 3'd1;
  assign kw_match    = (kw_sel != 2'd3) && (kw_prog < jtl_pkg::kw_len(kw_sel))
                       && (b == jtl_pkg::kw_char(kw_sel, kw_prog));

  always_comb begin
    idle_emit = 1'b0;
    idle_kind = jtl_pkg::TK_ERROR;
    idle_done = 1'b0;
    idle_mode = jtl_pkg::M_IDLE;
    idle_str  = 1'b0;
    idle_num  = 1'b0;
    idle_kw   = 1'b0;
    idle_sel  = jtl_pkg::KW_SEL_TRUE;
    unique case (b) inside
      jtl_pkg::CH_NUL: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_END;
        idle_done = 1'b1;
      end
      jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR: ;
      jtl_pkg::CH_LBRACE: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_LBRACE;
      end
      jtl_pkg::CH_RBRACE: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_RBRACE;
      end
      jtl_pkg::CH_LBRACKET: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_LBRACKET;
      end
      jtl_pkg::CH_RBRACKET: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_RBRACKET;
      end
      jtl_pkg::CH_COLON: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_COLON;
      end
      jtl_pkg::CH_COMMA: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_COMMA;
      end
      jtl_pkg::CH_QUOTE: begin
        idle_mode = jtl_pkg::M_STR;
        idle_str  = 1'b1;
      end
      jtl_pkg::CH_LC_T: begin
        idle_mode = jtl_pkg::M_KW;
        idle_kw   = 1'b1;
        idle_sel  = jtl_pkg::KW_SEL_TRUE;
      end
      jtl_pkg::CH_LC_F: begin
        idle_mode = jtl_pkg::M_KW;
        idle_kw   = 1'b1;
        idle_sel  = jtl_pkg::KW_SEL_FALSE;
      end
      jtl_pkg::CH_LC_N: begin
        idle_mode = jtl_pkg::M_KW;
        idle_kw   = 1'b1;
        idle_sel  = jtl_pkg::KW_SEL_NULL;
      end
      [jtl_pkg::CH_ZERO:jtl_pkg::CH_NINE], jtl_pkg::CH_MINUS: begin
        idle_mode = jtl_pkg::M_INT;
        idle_num  = 1'b1;
      end
      default: begin
        idle_emit = 1'b1;
        idle_kind = jtl_pkg::TK_ERROR;
        idle_mode = jtl_pkg::M_HOLD;
      end
    endcase
  end

  always_comb begin
    mode_next      = mode;
    kw_prog_next   = kw_prog;
    kw_sel_next    = kw_sel;
    tok_begin_next = tok_begin;
    pos_next       = here_plus1;
    use_idle       = 1'b0;
    done           = 1'b0;
    n_tok          = 2'd0;
    tok0           = '0;
    tok1           = '0;
    unique case (mode)
      jtl_pkg::M_IDLE: begin
        use_idle = 1'b1;
        n_tok    = {1'b0, idle_emit};
        tok0.kind = idle_kind;
      end
      jtl_pkg::M_STR: begin
        if (b == jtl_pkg::CH_QUOTE) begin
          n_tok       = 2'd1;
          tok0.kind   = jtl_pkg::TK_STRING;
          tok0.start  = 16'(tok_begin);
          tok0.length = 16'(run_len);
          mode_next   = jtl_pkg::M_IDLE;
        end else if (b == jtl_pkg::CH_BSLASH) begin
          mode_next = jtl_pkg::M_ESC;
        end else if (b == jtl_pkg::CH_NUL) begin
          n_tok     = 2'd2;
          tok0.kind = jtl_pkg::TK_ERROR;
          tok1.kind = jtl_pkg::TK_END;
          done      = 1'b1;
        end
      end
      jtl_pkg::M_ESC: begin
        if (b == jtl_pkg::CH_NUL) begin
          n_tok     = 2'd2;
          tok0.kind = jtl_pkg::TK_ERROR;
          tok1.kind = jtl_pkg::TK_END;
          done      = 1'b1;
        end else begin
          mode_next = jtl_pkg::M_STR;
        end
      end
      jtl_pkg::M_INT, jtl_pkg::M_FRAC: begin
        if (is_digit) begin
          mode_next = mode;
        end else if (mode == jtl_pkg::M_INT && b == jtl_pkg::CH_DOT) begin
          mode_next = jtl_pkg::M_FRAC;
        end else begin
          // close the number, then lex the same byte from idle
          use_idle    = 1'b1;
          n_tok       = idle_emit ? 2'd2 : 2'd1;
          tok0.kind   = jtl_pkg::TK_NUMBER;
          tok0.start  = 16'(tok_begin);
          tok0.length = 16'(run_len);
          tok1.kind   = idle_kind;
        end
      end
      jtl_pkg::M_KW: begin
        if (kw_match) begin
          kw_prog_next = kw_prog_inc;
          if (kw_prog_inc == jtl_pkg::kw_len(kw_sel)) begin
            n_tok        = 2'd1;
            tok0.kind    = 4'(jtl_pkg::TK_TRUE + kw_sel);
            mode_next    = jtl_pkg::M_IDLE;
            kw_prog_next = 3'd0;
          end
        end else begin
          n_tok        = 2'd1;
          tok0.kind    = jtl_pkg::TK_ERROR;
          kw_prog_next = 3'd0;
          if (b == jtl_pkg::CH_NUL) begin
            n_tok     = 2'd2;
            tok1.kind = jtl_pkg::TK_END;
            done      = 1'b1;
          end else begin
            mode_next = jtl_pkg::M_HOLD;
          end
        end
      end
      default: begin
        // hold after an error until the end byte
        if (b == jtl_pkg::CH_NUL) begin
          n_tok     = 2'd1;
          tok0.kind = jtl_pkg::TK_END;
          done      = 1'b1;
        end else begin
          mode_next = jtl_pkg::M_HOLD;
        end
      end
    endcase

    if (use_idle) begin
      mode_next = idle_mode;
      done      = idle_done;
      if (idle_str) tok_begin_next = here_plus1;
      if (idle_num) tok_begin_next = pos;
      if (idle_kw) begin
        kw_sel_next  = idle_sel;
        kw_prog_next = 3'd1;
      end
    end

    if (done) begin
      mode_next      = jtl_pkg::M_IDLE;
      kw_prog_next   = 3'd0;
      kw_sel_next    = 2'd0;
      tok_begin_next = '0;
      pos_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jtl_pkg::M_IDLE;
      kw_prog   <= 3'd0;
      kw_sel    <= 2'd0;
      pos       <= '0;
      tok_begin <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      kw_prog   <= kw_prog_next;
      kw_sel    <= kw_sel_next;
      pos       <= pos_next;
      tok_begin <= tok_begin_next;
    end
  end

  assign push         = accept && (n_tok != 2'd0);
  assign grp.two_tok  = (n_tok == 2'd2);
  assign grp.tok0     = tok0;
  assign grp.tok1     = tok1;

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && b == jtl_pkg::CH_NUL) |=> (pos == '0 && mode == jtl_pkg::M_IDLE))
    else $error("end byte did not restart the lexer");

  a_hold_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == jtl_pkg::M_HOLD && b != jtl_pkg::CH_NUL) |-> !push)
    else $error("token emitted while holding after an error");

endmodule

[design/jtl_queue.sv]
// Short FIFO of token groups between lexer front end and output back end.
// Depends on jtl_pkg.
module jtl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jtl_pkg::group_t wr_data,
  input  logic            pop,
  output jtl_pkg::group_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int unsigned DEPTH  = jtl_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  jtl_pkg::group_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (!do_push && do_pop) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full token queue");

endmodule

[design/jtl_back.sv]
// Back end: splits token groups into single tokens behind an output register.
// Depends on jtl_pkg and jtl_token_if.
module jtl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  jtl_pkg::group_t q_data,
  output logic            q_pop,
  jtl_token_if.source     out_ch
);

  logic            load;
  logic            pend_valid;
  jtl_pkg::token_t pend;

  assign load  = !out_ch.valid || out_ch.ready;
  assign q_pop = load && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_ch.valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else if (!q_empty) begin
        out_ch.valid <= 1'b1;
        pend_valid   <= q_data.two_tok;
      end else begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_ch.token_kind   <= pend.kind;
        out_ch.value_start  <= pend.start;
        out_ch.value_length <= pend.length;
        out_ch.last_of_run  <= 1'b1;
      end else begin
        out_ch.token_kind   <= q_data.tok0.kind;
        out_ch.value_start  <= q_data.tok0.start;
        out_ch.value_length <= q_data.tok0.length;
        out_ch.last_of_run  <= !q_data.two_tok;
        pend                <= q_data.tok1;
      end
    end
  end

  a_pend_behind_first: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_ch.valid && !out_ch.last_of_run))
    else $error("second token pending without its first on the output");

endmodule

[design/json_token_lexer_core.sv]
// Top level of the JSON token lexer: front end, group queue and back end.
// Depends on jtl_pkg, jtl_byte_if, jtl_token_if, jtl_front, jtl_queue, jtl_back.
//
// Usage:
//   byte_ch  (sink)   : one document byte per request; a zero byte ends the
//                       document and returns position counting to zero.
//   token_ch (source) : one token per request with kind, value offset,
//                       value length and last_of_run, which marks the final
//                       token caused by a given byte.
// Throughput: one byte per cycle while the queue is not full. A byte that
//   closes a number and is itself a token yields two tokens; the back end
//   hands them out one after the other, so output is one token per cycle
//   while token_ch is ready, limited by the single output register.
// Path: a token's group is written into a queue slot and then loaded into
//   the output register; the second of two tokens waits in a pending
//   register and follows once the first is taken.
// Stalls: when token_ch is held off, groups collect in a four-entry queue;
//   byte_ch.ready drops only once that queue is full.
// Reset: synchronous, active high; lexer returns to idle between tokens,
//   position and token start clear, queue and output empty.
module json_token_lexer_core #(
  parameter int unsigned POSITION_BITS = jtl_pkg::POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  jtl_byte_if.sink    byte_ch,
  jtl_token_if.source token_ch
);

  // tokens from one byte, handed from the front end to the queue
  jtl_pkg::group_t push_grp;
  jtl_pkg::group_t head_grp;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // lexer state machine, one byte per accepted request
  jtl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .q_full (q_full),
    .push   (push),
    .grp    (push_grp)
  );

  // decouple lexing from output back-pressure
  jtl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_grp),
    .pop     (pop),
    .rd_data (head_grp),
    .full    (q_full),
    .empty   (q_empty)
  );

  // serialise groups into single tokens behind the output register
  jtl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (head_grp),
    .q_pop   (pop),
    .out_ch  (token_ch)
  );

endmodule
